/* src/ocs_pkg.sv */
// ----------------------------------------------------------------------------
// ocs_pkg
// Shared types and constants for the order cancel selector: field widths,
// action, status and cancel mode codes, and the controller/datapath links.
// ----------------------------------------------------------------------------
package ocs_pkg;

   // default table depth
   localparam int DEPTH_DEF = 32;

   // field widths
   localparam int ID_W     = 16;
   localparam int PRICE_W  = 32;
   localparam int MODE_W   = 4;
   localparam int STATUS_W = 2;

   // action codes
   localparam logic ACT_ADD    = 1'b0;
   localparam logic ACT_CANCEL = 1'b1;

   // side codes
   localparam logic SIDE_ASK = 1'b0;
   localparam logic SIDE_BID = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_CANCELLED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_MATCH  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ADDED     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

   // cancel mode codes
   localparam logic [MODE_W-1:0] M_RECENT      = 4'd0;
   localparam logic [MODE_W-1:0] M_RECENT_ASK  = 4'd1;
   localparam logic [MODE_W-1:0] M_RECENT_BID  = 4'd2;
   localparam logic [MODE_W-1:0] M_OLDEST      = 4'd3;
   localparam logic [MODE_W-1:0] M_OLDEST_ASK  = 4'd4;
   localparam logic [MODE_W-1:0] M_OLDEST_BID  = 4'd5;
   localparam logic [MODE_W-1:0] M_ALL         = 4'd6;
   localparam logic [MODE_W-1:0] M_ALL_ASKS    = 4'd7;
   localparam logic [MODE_W-1:0] M_ALL_BIDS    = 4'd8;
   localparam logic [MODE_W-1:0] M_CLOSE_ASK   = 4'd9;
   localparam logic [MODE_W-1:0] M_CLOSE_BID   = 4'd10;
   localparam logic [MODE_W-1:0] M_FAR_ASK     = 4'd11;
   localparam logic [MODE_W-1:0] M_FAR_BID     = 4'd12;

   // one table entry
   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic               side;
      logic [PRICE_W-1:0] price;
   } entry_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;     // capture the incoming transaction
      logic add;      // append the order and post the add result
      logic sweep;    // walk the table
      logic comp;     // the walk removes selected orders
      logic restart;  // rewind the walk for the compaction pass
      logic commit;   // take the compacted count
      logic miss;     // post the nothing-matched result
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic done;      // walk has passed the last entry
      logic found;     // scan selected at least one order
      logic out_free;  // result register can take a result
   } sts_type;

endpackage

/* src/order_cancel_selector_unit.sv */
// ----------------------------------------------------------------------------
// order_cancel_selector_unit
// Age-ordered table of open orders with add and mode-driven cancel.
// ----------------------------------------------------------------------------
// An add transaction appends an order and returns one result (added, or
// rejected when the table is full). A cancel transaction walks the table
// twice through its single read port: a scan picks the orders to remove,
// then a compaction pass returns one result per removed order, oldest
// first, and closes the gap; results wait while the result side is not
// ready. A cancel that removes nothing returns a single nothing-matched
// result. One transaction is worked on at a time; the next one is taken
// in the cycle after the previous one finishes, which for a cancel that
// removes orders is the cycle after its compaction pass ends.
module order_cancel_selector_unit #(
   parameter int DEPTH = ocs_pkg::DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_action,
   input  logic [ocs_pkg::ID_W-1:0]      req_order_id,
   input  logic                          req_side,
   input  logic [ocs_pkg::PRICE_W-1:0]   req_price,
   input  logic [ocs_pkg::MODE_W-1:0]    req_cancel_mode,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ocs_pkg::STATUS_W-1:0]  rsp_status,
   output logic [ocs_pkg::ID_W-1:0]      rsp_cancelled_id,
   output logic                          rsp_last
);
   import ocs_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencing
   ocs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // table and result path
   ocs_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_order_id     (req_order_id),
      .req_side         (req_side),
      .req_price        (req_price),
      .req_cancel_mode  (req_cancel_mode),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_cancelled_id (rsp_cancelled_id),
      .rsp_last         (rsp_last)
   );

endmodule

/* src/ocs_ctrl.sv */
// ----------------------------------------------------------------------------
// ocs_ctrl
// Controller state machine: sequences add, scan, compaction and the
// nothing-matched result, and drives the datapath by command signals.
// ----------------------------------------------------------------------------
module ocs_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_action,
   output logic             req_ready,
   input  ocs_pkg::sts_type sts,
   output ocs_pkg::cmd_type cmd
);
   import ocs_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_ADD  = 5'b00010,
      S_SCAN = 5'b00100,
      S_COMP = 5'b01000,
      S_MISS = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = (req_action == ACT_ADD) ? S_ADD : S_SCAN;
            end
         end
         S_ADD: begin
            if (sts.out_free) begin
               cmd.add  = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            cmd.sweep = 1'b1;
            if (sts.done) begin
               cmd.restart = 1'b1;
               state_in    = sts.found ? S_COMP : S_MISS;
            end
         end
         S_COMP: begin
            cmd.sweep = 1'b1;
            cmd.comp  = 1'b1;
            if (sts.done) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_MISS: begin
            if (sts.out_free) begin
               cmd.miss = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* src/ocs_dpath.sv */
// ----------------------------------------------------------------------------
// ocs_dpath
// Datapath: order table memory, fill count, walk pointers, selection logic
// for the cancel modes and the result register.
// ----------------------------------------------------------------------------
module ocs_dpath #(
   parameter int DEPTH = ocs_pkg::DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ocs_pkg::cmd_type              cmd,
   output ocs_pkg::sts_type              sts,
   input  logic [ocs_pkg::ID_W-1:0]      req_order_id,
   input  logic                          req_side,
   input  logic [ocs_pkg::PRICE_W-1:0]   req_price,
   input  logic [ocs_pkg::MODE_W-1:0]    req_cancel_mode,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ocs_pkg::STATUS_W-1:0]  rsp_status,
   output logic [ocs_pkg::ID_W-1:0]      rsp_cancelled_id,
   output logic                          rsp_last
);
   import ocs_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   // order table
   entry_type mem [DEPTH];

   // transaction and walk state
   entry_type            new_entry_ff;
   logic [MODE_W-1:0]    mode_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     rd_idx_ff;
   logic [CNT_W-1:0]     keep_ff;
   entry_type            rd_data_ff;
   logic [IDX_W-1:0]     stage_idx_ff;
   logic                 stage_vld_ff;
   logic                 found_ff;
   logic [IDX_W-1:0]     pick_ff;
   logic [PRICE_W-1:0]   best_ff;

   // result register
   logic                 rsp_valid_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [ID_W-1:0]      rsp_id_ff;
   logic                 rsp_last_ff;

   logic                 want_bid;
   logic                 any_side;
   logic                 multi;
   logic                 side_ok;
   logic                 take;
   logic                 sel;
   logic                 out_free;
   logic                 stage_done;
   logic                 advance;
   logic                 issue;
   logic                 keep_wr;
   logic                 add_wr;
   logic                 emit_cancel;
   logic                 mem_we;
   logic [IDX_W-1:0]     mem_wa;
   entry_type            mem_wd;
   logic                 rsp_load;
   logic [STATUS_W-1:0]  rsp_status_in;
   logic [ID_W-1:0]      rsp_id_in;

   // mode decode
   always_comb begin
      want_bid = (mode_ff == M_RECENT_BID) || (mode_ff == M_OLDEST_BID) ||
                 (mode_ff == M_ALL_BIDS) || (mode_ff == M_CLOSE_BID) ||
                 (mode_ff == M_FAR_BID);
      any_side = (mode_ff == M_RECENT) || (mode_ff == M_OLDEST) || (mode_ff == M_ALL);
      multi    = (mode_ff == M_ALL) || (mode_ff == M_ALL_ASKS) || (mode_ff == M_ALL_BIDS);
      side_ok  = any_side || (rd_data_ff.side == want_bid);
   end

   // scan: does the staged entry become the current pick
   always_comb begin
      case (mode_ff)
         M_RECENT, M_RECENT_ASK, M_RECENT_BID,
         M_ALL, M_ALL_ASKS, M_ALL_BIDS: begin
            take = side_ok;
         end
         M_OLDEST, M_OLDEST_ASK, M_OLDEST_BID: begin
            take = side_ok && !found_ff;
         end
         M_CLOSE_ASK: begin
            take = side_ok && (!found_ff || (rd_data_ff.price <= best_ff));
         end
         M_CLOSE_BID: begin
            take = side_ok && (!found_ff || (rd_data_ff.price >= best_ff));
         end
         M_FAR_ASK: begin
            take = side_ok && (!found_ff || (rd_data_ff.price > best_ff));
         end
         M_FAR_BID: begin
            take = side_ok && (!found_ff || (rd_data_ff.price < best_ff));
         end
         default: begin
            take = 1'b0;
         end
      endcase
   end

   // walk control
   always_comb begin
      out_free    = !rsp_valid_ff || rsp_ready;
      sel         = multi ? side_ok : (stage_idx_ff == pick_ff);
      stage_done  = cmd.comp ? (!sel || out_free) : 1'b1;
      advance     = cmd.sweep && (!stage_vld_ff || stage_done);
      issue       = advance && (rd_idx_ff < count_ff);
      keep_wr     = cmd.comp && stage_vld_ff && !sel;
      emit_cancel = cmd.comp && stage_vld_ff && sel && out_free;
      add_wr      = cmd.add && (count_ff < FULL_CNT);
   end

   // table write port
   always_comb begin
      mem_we = add_wr || keep_wr;
      if (add_wr) begin
         mem_wa = count_ff[IDX_W-1:0];
         mem_wd = new_entry_ff;
      end else begin
         mem_wa = keep_ff[IDX_W-1:0];
         mem_wd = rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
   end

   // table read port
   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff   <= mem[rd_idx_ff[IDX_W-1:0]];
         stage_idx_ff <= rd_idx_ff[IDX_W-1:0];
      end
   end

   // transaction capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         new_entry_ff.id    <= req_order_id;
         new_entry_ff.side  <= req_side;
         new_entry_ff.price <= req_price;
         mode_ff            <= req_cancel_mode;
      end
   end

   // pick tracking during the scan
   always_ff @(posedge clock) begin
      if (cmd.sweep && !cmd.comp && stage_vld_ff && take) begin
         pick_ff <= stage_idx_ff;
         best_ff <= rd_data_ff.price;
      end
   end

   // control registers of the walk
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         keep_ff      <= '0;
         stage_vld_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         if (cmd.load || cmd.restart) begin
            rd_idx_ff    <= '0;
            keep_ff      <= '0;
            stage_vld_ff <= 1'b0;
         end else begin
            if (issue) begin
               rd_idx_ff <= rd_idx_ff + 1'b1;
            end
            if (advance) begin
               stage_vld_ff <= issue;
            end
            if (keep_wr) begin
               keep_ff <= keep_ff + 1'b1;
            end
         end
         if (cmd.load) begin
            found_ff <= 1'b0;
         end else if (cmd.sweep && !cmd.comp && stage_vld_ff && take) begin
            found_ff <= 1'b1;
         end
         if (add_wr) begin
            count_ff <= count_ff + 1'b1;
         end else if (cmd.commit) begin
            count_ff <= keep_ff;
         end
      end
   end

   // result register
   always_comb begin
      rsp_load      = cmd.add || cmd.miss || emit_cancel;
      rsp_status_in = ST_CANCELLED;
      rsp_id_in     = '0;
      if (cmd.add) begin
         rsp_status_in = add_wr ? ST_ADDED : ST_FULL;
      end else if (cmd.miss) begin
         rsp_status_in = ST_NO_MATCH;
      end else begin
         rsp_id_in = rd_data_ff.id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_last_ff   <= emit_cancel ? (stage_idx_ff == pick_ff) : 1'b1;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_cancelled_id = rsp_id_ff;
   assign rsp_last         = rsp_last_ff;

   assign sts.done     = !stage_vld_ff && (rd_idx_ff == count_ff);
   assign sts.found    = found_ff;
   assign sts.out_free = out_free;

   // fill count stays within the table
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("order count beyond table depth");

   // compaction never writes ahead of the read pointer
   a_keep_behind: assert property (@(posedge clock) disable iff (reset)
      keep_ff <= rd_idx_ff)
      else $error("compaction pointer ahead of read pointer");

   // an add with room grows the table by one
   a_add_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.add && (count_ff < FULL_CNT)) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("add did not grow the table");

   // a result is never loaded over one that is still waiting
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !rsp_load)
      else $error("result register overrun");

endmodule

/* tb/order_cancel_selector_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// order_cancel_selector_unit_tb
// Self-checking bench for the order table: a short scripted sequence, then
// random add and cancel transactions in three phases with a falling add rate.
// A behavioral copy of the order table predicts results (a scripted row may
// give its own); results are checked field by field in order of arrival.
// ----------------------------------------------------------------------------
module order_cancel_selector_unit_tb;
   import ocs_pkg::*;

   localparam int DEPTH       = DEPTH_DEF;
   localparam int SCRIPT_LEN  = 23;
   localparam int RANDOM_LEN  = 450;
   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_WAIT  = 100;

   // mode code that selects nothing
   localparam logic [MODE_W-1:0] M_UNUSED_LO = 4'd13;

   typedef struct packed {
      logic               action;
      logic [ID_W-1:0]    order_id;
      logic               side;
      logic [PRICE_W-1:0] price;
      logic [MODE_W-1:0]  mode;
      logic               typed;
      logic [STATUS_W-1:0] t_status;
      logic [ID_W-1:0]    t_id;
   } stim_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     id;
      logic                last;
   } outcome_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_action;
   logic [ID_W-1:0]     req_order_id;
   logic                req_side;
   logic [PRICE_W-1:0]  req_price;
   logic [MODE_W-1:0]   req_cancel_mode;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [STATUS_W-1:0] rsp_status;
   logic [ID_W-1:0]     rsp_cancelled_id;
   logic                rsp_last;

   // typed expectation riding along with the driven transaction
   logic                row_typed;
   logic [STATUS_W-1:0] row_status;
   logic [ID_W-1:0]     row_id;

   logic                calm;
   int                  quiet;
   int                  mismatches;
   int                  depth_before;
   outcome_type         head;
   stim_type            script [SCRIPT_LEN];

   // behavioral copy of the order table
   entry_type           order_book [DEPTH];
   int                  book_size;
   outcome_type         awaited_reports [$];

   order_cancel_selector_unit #(.DEPTH(DEPTH)) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_order_id     (req_order_id),
      .req_side         (req_side),
      .req_price        (req_price),
      .req_cancel_mode  (req_cancel_mode),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_cancelled_id (rsp_cancelled_id),
      .rsp_last         (rsp_last)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // append one expected result at the tail of the queue
   task automatic queue_result(input outcome_type o);
      awaited_reports.insert(awaited_reports.size(), o);
   endtask

   // apply one transaction to the table copy and queue the results it causes
   task automatic apply_to_book(input logic act, input logic [ID_W-1:0] id,
                                input logic sd, input logic [PRICE_W-1:0] px,
                                input logic [MODE_W-1:0] mode);
      int                 pick;
      int                 keep;
      logic [PRICE_W-1:0] best;
      logic               want;
      logic               take;
      logic               hit [DEPTH];
      bit                 any;
      pick = -1;
      keep = 0;
      best = '0;
      any  = 1'b0;
      foreach (hit[i]) hit[i] = 1'b0;
      if (act == ACT_ADD) begin
         if (book_size >= DEPTH) begin
            queue_result('{ST_FULL, '0, 1'b1});
         end else begin
            order_book[book_size] = '{id, sd, px};
            book_size++;
            queue_result('{ST_ADDED, '0, 1'b1});
         end
         return;
      end
      case (mode)
         M_RECENT_BID, M_OLDEST_BID, M_ALL_BIDS, M_CLOSE_BID, M_FAR_BID: want = SIDE_BID;
         default: want = SIDE_ASK;
      endcase
      // pick the orders to remove
      if (book_size > 0) begin
         case (mode)
            M_RECENT: pick = book_size - 1;
            M_RECENT_ASK, M_RECENT_BID: begin
               for (int i = book_size - 1; i >= 0; i--)
                  if (pick < 0 && order_book[i].side == want) pick = i;
            end
            M_OLDEST: pick = 0;
            M_OLDEST_ASK, M_OLDEST_BID: begin
               for (int i = 0; i < book_size; i++)
                  if (pick < 0 && order_book[i].side == want) pick = i;
            end
            M_ALL: begin
               for (int i = 0; i < book_size; i++) hit[i] = 1'b1;
            end
            M_ALL_ASKS, M_ALL_BIDS: begin
               for (int i = 0; i < book_size; i++)
                  if (order_book[i].side == want) hit[i] = 1'b1;
            end
            M_CLOSE_ASK, M_CLOSE_BID, M_FAR_ASK, M_FAR_BID: begin
               // oldest to newest; the comparison decides ties
               for (int i = 0; i < book_size; i++) begin
                  if (order_book[i].side == want) begin
                     if (pick < 0) take = 1'b1;
                     else if (mode == M_CLOSE_ASK) take = order_book[i].price <= best;
                     else if (mode == M_CLOSE_BID) take = order_book[i].price >= best;
                     else if (mode == M_FAR_ASK) take = order_book[i].price > best;
                     else take = order_book[i].price < best;
                     if (take) begin
                        pick = i;
                        best = order_book[i].price;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
      if (pick >= 0) hit[pick] = 1'b1;
      // report removed orders oldest first and close the gaps
      for (int i = 0; i < book_size; i++) begin
         if (hit[i]) begin
            queue_result('{ST_CANCELLED, order_book[i].id, 1'b0});
            any = 1'b1;
         end else begin
            order_book[keep] = order_book[i];
            keep++;
         end
      end
      book_size = keep;
      if (!any) queue_result('{ST_NO_MATCH, '0, 1'b1});
      else awaited_reports[awaited_reports.size() - 1].last = 1'b1;
   endtask

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] wanted);
      $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, wanted);
      mismatches++;
   endtask

   // offer one transaction and hold it until taken
   task automatic send_order_item(input stim_type r);
      while (!calm && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= r.action;
      req_order_id    <= r.order_id;
      req_side        <= r.side;
      req_price       <= r.price;
      req_cancel_mode <= r.mode;
      row_typed       <= r.typed;
      row_status      <= r.t_status;
      row_id          <= r.t_id;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic stim_type make_random_item(input int k);
      stim_type r;
      int       add_pct;
      int       kind;
      add_pct = (k < 150) ? 80 : (k < 300) ? 55 : 40;
      r.action   = ($urandom_range(99) < add_pct) ? ACT_ADD : ACT_CANCEL;
      r.order_id = ID_W'($urandom);
      r.side     = 1'($urandom_range(1));
      // narrow prices give ties, some sit at the extremes, the rest span the full range
      kind = $urandom_range(9);
      if (kind < 4) r.price = PRICE_W'($urandom_range(7));
      else if (kind == 4) r.price = '0;
      else if (kind == 5) r.price = '1;
      else r.price = PRICE_W'($urandom);
      r.mode     = ($urandom_range(9) == 0) ? MODE_W'($urandom_range(15))
                                            : MODE_W'($urandom_range(12));
      r.typed    = 1'b0;
      r.t_status = '0;
      r.t_id     = '0;
      return r;
   endfunction

   // result side backpressure
   always @(negedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 12);
   end

   // check results and predict on every accepted transaction
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_reports.size() == 0) begin
               flag_mismatch("unexpected result", {rsp_status, rsp_cancelled_id}, 0);
            end else begin
               head = awaited_reports.pop_front();
               if (rsp_status !== head.status)
                  flag_mismatch("status", rsp_status, head.status);
               if (rsp_cancelled_id !== head.id)
                  flag_mismatch("cancelled_id", rsp_cancelled_id, head.id);
               if (rsp_last !== head.last)
                  flag_mismatch("last", rsp_last, head.last);
            end
         end
         if (req_valid && req_ready) begin
            depth_before = awaited_reports.size();
            apply_to_book(req_action, req_order_id, req_side, req_price, req_cancel_mode);
            if (row_typed) begin
               while (awaited_reports.size() > depth_before)
                  awaited_reports.delete(awaited_reports.size() - 1);
               queue_result('{row_status, row_id, 1'b1});
            end
         end
         quiet <= ((rsp_valid && rsp_ready) || (req_valid && req_ready)) ? 0 : quiet + 1;
      end
   end

   // watchdog on cycles with no transaction
   initial begin
      while (quiet < QUIET_LIMIT) @(negedge clock);
      $display("order_cancel_selector_unit_tb: FAIL");
      $finish;
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_action      = ACT_ADD;
      req_order_id    = '0;
      req_side        = SIDE_ASK;
      req_price       = '0;
      req_cancel_mode = M_RECENT;
      row_typed       = 1'b0;
      row_status      = '0;
      row_id          = '0;
      calm            = 1'b0;

      // scripted sequence; ignored fields carry junk
      script = '{
         '{ACT_CANCEL, 16'hFFFF, SIDE_BID, 32'hFFFF_FFFF, M_RECENT,   1'b1, ST_NO_MATCH, 16'h0},
         '{ACT_ADD,    16'h0000, SIDE_ASK, 32'h0,         M_ALL,      1'b1, ST_ADDED,    16'h0},
         '{ACT_ADD,    16'hFFFF, SIDE_BID, 32'hFFFF_FFFF, 4'hF,       1'b1, ST_ADDED,    16'h0},
         '{ACT_ADD,    16'h1234, SIDE_ASK, 32'd100,       M_FAR_BID,  1'b0, ST_ADDED,    16'h0},
         '{ACT_ADD,    16'h2345, SIDE_BID, 32'd100,       M_RECENT,   1'b0, ST_ADDED,    16'h0},
         '{ACT_ADD,    16'h3456, SIDE_ASK, 32'd100,       M_OLDEST,   1'b0, ST_ADDED,    16'h0},
         '{ACT_ADD,    16'h4567, SIDE_BID, 32'd50,        M_ALL,      1'b0, ST_ADDED,    16'h0},
         '{ACT_CANCEL, 16'hAAAA, SIDE_BID, 32'h5555_5555, M_CLOSE_ASK, 1'b1, ST_CANCELLED, 16'h0000},
         '{ACT_CANCEL, 16'h5555, SIDE_ASK, 32'hAAAA_AAAA, M_CLOSE_BID, 1'b1, ST_CANCELLED, 16'hFFFF},
         '{ACT_CANCEL, 16'h0001, SIDE_ASK, 32'd1,         M_FAR_ASK,  1'b0, ST_ADDED,    16'h0},
         '{ACT_CANCEL, 16'h0002, SIDE_BID, 32'd2,         M_FAR_BID,  1'b0, ST_ADDED,    16'h0},
         '{ACT_CANCEL, 16'h0003, SIDE_ASK, 32'd3,         M_UNUSED_LO, 1'b1, ST_NO_MATCH, 16'h0},
         '{ACT_CANCEL, 16'h0004, SIDE_BID, 32'd4,         M_RECENT_BID, 1'b0, ST_ADDED,  16'h0},
         '{ACT_CANCEL, 16'h0005, SIDE_ASK, 32'd5,         M_RECENT_ASK, 1'b0, ST_ADDED,  16'h0},
         '{ACT_ADD,    16'h0010, SIDE_ASK, 32'd7,         M_ALL_ASKS, 1'b0, ST_ADDED,    16'h0},
         '{ACT_ADD,    16'h0011, SIDE_BID, 32'd7,         M_ALL_BIDS, 1'b0, ST_ADDED,    16'h0},
         '{ACT_ADD,    16'h0012, SIDE_ASK, 32'd9,         M_CLOSE_BID, 1'b0, ST_ADDED,   16'h0},
         '{ACT_ADD,    16'h0013, SIDE_BID, 32'd9,         M_FAR_ASK,  1'b0, ST_ADDED,    16'h0},
         '{ACT_ADD,    16'h0014, SIDE_ASK, 32'd7,         M_OLDEST_ASK, 1'b0, ST_ADDED,  16'h0},
         '{ACT_CANCEL, 16'h0006, SIDE_BID, 32'd6,         M_CLOSE_ASK, 1'b0, ST_ADDED,   16'h0},
         '{ACT_CANCEL, 16'h0007, SIDE_ASK, 32'd7,         M_OLDEST,   1'b0, ST_ADDED,    16'h0},
         '{ACT_CANCEL, 16'h0008, SIDE_BID, 32'd8,         M_OLDEST_BID, 1'b0, ST_ADDED,  16'h0},
         '{ACT_CANCEL, 16'h0009, SIDE_ASK, 32'd9,         M_ALL,      1'b0, ST_ADDED,    16'h0}
      };

      // synchronous reset
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (script[i]) send_order_item(script[i]);

      // random phases, with one stretch free of idling on both sides
      for (int k = 0; k < RANDOM_LEN; k++) begin
         calm <= (k >= 200 && k < 280);
         send_order_item(make_random_item(k));
      end
      req_valid <= 1'b0;
      calm      <= 1'b0;

      // drain, then let the block settle
      while (awaited_reports.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);

      if (mismatches == 0)
         $display("order_cancel_selector_unit_tb: PASS");
      else
         $display("order_cancel_selector_unit_tb: FAIL");
      $finish;
   end

endmodule

/* filelist.f */
src/ocs_pkg.sv
src/ocs_ctrl.sv
src/ocs_dpath.sv
src/order_cancel_selector_unit.sv
tb/order_cancel_selector_unit_tb.sv
